// ===== src/apid_pkg.sv =====
// apid_pkg: shared widths, register indexes and beat structs for the
// angle position PID loop. No dependencies.
package apid_pkg;

    // Encoder and error widths
    localparam int EncW        = 14;
    localparam int ErrW        = 15;
    localparam int DiffW       = 16;
    localparam int WrapW       = 16;
    localparam int DataW       = 32;

    // One revolution of the encoder and the wrap bounds of the error
    localparam int CountsPerRev = 16384;
    localparam int HalfRev      = CountsPerRev / 2;

    // Product and sum widths in the back end
    localparam int ProdPW  = DataW + ErrW;
    localparam int ProdDW  = DataW + DiffW;
    localparam int AccW    = ProdPW + 1;
    localparam int PdW     = ProdDW + 1;
    localparam int OutSumW = PdW + 1;

    // Decoupling queue
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // Configuration register indexes
    localparam int CfgIdxW = 3;
    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_TARGET      = 3'd3,
        CFG_ZERO        = 3'd4,
        CFG_LIMIT_LOW   = 3'd5,
        CFG_LIMIT_HIGH  = 3'd6,
        CFG_DIR_REVERSE = 3'd7
    } cfg_index_t;

    // One classified beat: wrapped error and its change from the last one
    typedef struct packed {
        logic signed [ErrW-1:0]  err;
        logic signed [DiffW-1:0] diff;
    } item_t;

    // Settings used by the front end
    typedef struct packed {
        logic [EncW-1:0] target_count;
        logic [EncW-1:0] zero_count;
        logic            dir_reverse;
    } front_cfg_t;

    // Settings used by the back end
    typedef struct packed {
        logic signed [DataW-1:0] gain_p;
        logic signed [DataW-1:0] gain_i;
        logic signed [DataW-1:0] gain_d;
        logic signed [DataW-1:0] limit_low;
        logic signed [DataW-1:0] limit_high;
    } back_cfg_t;

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

// ===== src/apid_front.sv =====
// apid_front: turns an encoder beat into the wrapped angle error and its
// change since the previous beat. Depends on apid_pkg.
module apid_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  apid_pkg::front_cfg_t   cfg,
    input  logic                   accept,
    input  logic [apid_pkg::EncW-1:0] encoder_count,
    output apid_pkg::item_t        item
);

    localparam logic signed [apid_pkg::WrapW-1:0] HalfPos =
        apid_pkg::WrapW'(apid_pkg::HalfRev);
    localparam logic signed [apid_pkg::WrapW-1:0] HalfNeg =
        -apid_pkg::WrapW'(apid_pkg::HalfRev);
    localparam logic signed [apid_pkg::WrapW-1:0] Rev =
        apid_pkg::WrapW'(apid_pkg::CountsPerRev);

    logic [apid_pkg::EncW-1:0]         angle;
    logic [apid_pkg::EncW-1:0]         rel;
    logic signed [apid_pkg::WrapW-1:0] err_raw;
    logic signed [apid_pkg::WrapW-1:0] err_wrap;
    logic signed [apid_pkg::ErrW-1:0]  err;
    logic signed [apid_pkg::ErrW-1:0]  prev_err_reg;
    logic signed [apid_pkg::ErrW-1:0]  prev_err_next;

    // Direction and zero offset, modulo one turn
    always_comb
    begin
        angle = cfg.dir_reverse ? (~encoder_count + 1'b1) : encoder_count;
        rel   = angle - cfg.zero_count;
    end

    // Error to target, wrapped into a half turn either way
    always_comb
    begin
        err_raw = $signed({2'b00, cfg.target_count}) - $signed({2'b00, rel});
        if (err_raw > HalfPos)
        begin
            err_wrap = err_raw - Rev;
        end
        else if (err_raw < HalfNeg)
        begin
            err_wrap = err_raw + Rev;
        end
        else
        begin
            err_wrap = err_raw;
        end
        err = err_wrap[apid_pkg::ErrW-1:0];
    end

    // Beat toward the queue
    always_comb
    begin
        item.err  = err;
        item.diff = {err[apid_pkg::ErrW-1], err}
                  - {prev_err_reg[apid_pkg::ErrW-1], prev_err_reg};
        prev_err_next = accept ? err : prev_err_reg;
    end

    // Last error, for the derivative term
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
        end
        else
        begin
            prev_err_reg <= prev_err_next;
        end
    end

endmodule

// ===== src/apid_queue.sv =====
// apid_queue: short FIFO of classified beats between the front and back ends.
// Depends on apid_pkg.
module apid_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  apid_pkg::item_t          item_in,
    input  logic                     pop,
    output apid_pkg::item_t          item_out,
    output apid_pkg::queue_status_t  status
);

    apid_pkg::item_t               mem_reg [apid_pkg::QueueDepth];
    logic [apid_pkg::QPtrW-1:0]    wr_ptr_reg;
    logic [apid_pkg::QPtrW-1:0]    wr_ptr_next;
    logic [apid_pkg::QPtrW-1:0]    rd_ptr_reg;
    logic [apid_pkg::QPtrW-1:0]    rd_ptr_next;
    logic [apid_pkg::QCntW-1:0]    count_reg;
    logic [apid_pkg::QCntW-1:0]    count_next;
    logic                          do_pop;

    localparam logic [apid_pkg::QPtrW-1:0] LastPtr =
        apid_pkg::QPtrW'(apid_pkg::QueueDepth - 1);
    localparam logic [apid_pkg::QCntW-1:0] FullCnt =
        apid_pkg::QCntW'(apid_pkg::QueueDepth);

    // Status flags from the fill count
    always_comb
    begin
        status.full      = (count_reg == FullCnt);
        status.not_empty = (count_reg != '0);
        do_pop           = pop && status.not_empty;
        item_out         = mem_reg[rd_ptr_reg];
    end

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

`ifndef SYNTHESIS
    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("queue count beyond depth");

    // A push never lands on a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");
`endif

endmodule

// ===== src/apid_back.sv =====
// apid_back: PID arithmetic over three stages (products, integral update,
// output sum and clamp) with the output register. Depends on apid_pkg.
module apid_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  apid_pkg::back_cfg_t           cfg,
    input  apid_pkg::item_t               item,
    input  logic                          item_valid,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [apid_pkg::DataW-1:0] current_ref,
    output logic signed [apid_pkg::ErrW-1:0]  pos_error,
    output logic                          out_clamped
);

    localparam int DataW   = apid_pkg::DataW;
    localparam int ErrW    = apid_pkg::ErrW;
    localparam int ProdPW  = apid_pkg::ProdPW;
    localparam int ProdDW  = apid_pkg::ProdDW;
    localparam int AccW    = apid_pkg::AccW;
    localparam int PdW     = apid_pkg::PdW;
    localparam int OutSumW = apid_pkg::OutSumW;

    logic                      en;

    // Product stage
    logic                      p_valid_reg;
    logic signed [ProdPW-1:0]  prod_p_reg;
    logic signed [ProdPW-1:0]  prod_i_reg;
    logic signed [ProdDW-1:0]  prod_d_reg;
    logic signed [ErrW-1:0]    p_err_reg;
    logic signed [ProdPW-1:0]  prod_p_next;
    logic signed [ProdPW-1:0]  prod_i_next;
    logic signed [ProdDW-1:0]  prod_d_next;

    // Integral stage
    logic                      s_valid_reg;
    logic signed [DataW-1:0]   integral_reg;
    logic signed [DataW-1:0]   integral_next;
    logic signed [PdW-1:0]     pd_reg;
    logic signed [PdW-1:0]     pd_next;
    logic signed [ErrW-1:0]    s_err_reg;
    logic signed [AccW-1:0]    acc;
    logic signed [AccW-1:0]    lim_lo_acc;
    logic signed [AccW-1:0]    lim_hi_acc;

    // Output stage
    logic                      out_valid_reg;
    logic signed [DataW-1:0]   current_ref_reg;
    logic signed [DataW-1:0]   current_ref_next;
    logic signed [ErrW-1:0]    pos_error_reg;
    logic                      out_clamped_reg;
    logic                      out_clamped_next;
    logic signed [OutSumW-1:0] out_sum;
    logic signed [OutSumW-1:0] lim_lo_out;
    logic signed [OutSumW-1:0] lim_hi_out;

    // Whole back end moves when the output register is free
    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && item_valid;

    // Gain products
    always_comb
    begin
        prod_p_next = $signed(cfg.gain_p) * $signed(item.err);
        prod_i_next = $signed(cfg.gain_i) * $signed(item.err);
        prod_d_next = $signed(cfg.gain_d) * $signed(item.diff);
    end

    // Integral accumulate and clamp, high limit tested first; P and D products summed
    always_comb
    begin
        lim_lo_acc = {{(AccW-DataW){cfg.limit_low[DataW-1]}}, cfg.limit_low};
        lim_hi_acc = {{(AccW-DataW){cfg.limit_high[DataW-1]}}, cfg.limit_high};
        acc = {{(AccW-DataW){integral_reg[DataW-1]}}, integral_reg}
            + {{(AccW-ProdPW){prod_i_reg[ProdPW-1]}}, prod_i_reg};
        if (acc > lim_hi_acc)
        begin
            integral_next = cfg.limit_high;
        end
        else if (acc < lim_lo_acc)
        begin
            integral_next = cfg.limit_low;
        end
        else
        begin
            integral_next = acc[DataW-1:0];
        end
        pd_next = {{(PdW-ProdPW){prod_p_reg[ProdPW-1]}}, prod_p_reg}
                + {{(PdW-ProdDW){prod_d_reg[ProdDW-1]}}, prod_d_reg};
    end

    // Output sum and clamp
    always_comb
    begin
        lim_lo_out = {{(OutSumW-DataW){cfg.limit_low[DataW-1]}}, cfg.limit_low};
        lim_hi_out = {{(OutSumW-DataW){cfg.limit_high[DataW-1]}}, cfg.limit_high};
        out_sum = {{(OutSumW-PdW){pd_reg[PdW-1]}}, pd_reg}
                + {{(OutSumW-DataW){integral_reg[DataW-1]}}, integral_reg};
        if (out_sum > lim_hi_out)
        begin
            current_ref_next = cfg.limit_high;
            out_clamped_next = 1'b1;
        end
        else if (out_sum < lim_lo_out)
        begin
            current_ref_next = cfg.limit_low;
            out_clamped_next = 1'b1;
        end
        else
        begin
            current_ref_next = out_sum[DataW-1:0];
            out_clamped_next = 1'b0;
        end
    end

    // Stage valids and integral state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
        end
        else if (en)
        begin
            p_valid_reg   <= item_valid;
            s_valid_reg   <= p_valid_reg;
            out_valid_reg <= s_valid_reg;
            if (p_valid_reg)
            begin
                integral_reg <= integral_next;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_p_reg      <= prod_p_next;
            prod_i_reg      <= prod_i_next;
            prod_d_reg      <= prod_d_next;
            p_err_reg       <= item.err;
            pd_reg          <= pd_next;
            s_err_reg       <= p_err_reg;
            current_ref_reg <= current_ref_next;
            pos_error_reg   <= s_err_reg;
            out_clamped_reg <= out_clamped_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign current_ref = current_ref_reg;
    assign pos_error   = pos_error_reg;
    assign out_clamped = out_clamped_reg;

`ifndef SYNTHESIS
    // With ordered limits the kept integral lies between them
    a_integral_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        $past(en && p_valid_reg && (cfg.limit_low <= cfg.limit_high)) |->
            (integral_reg >= $past(cfg.limit_low)) &&
            (integral_reg <= $past(cfg.limit_high)))
        else $error("integral outside limits");

    // A beat in the integral stage reaches the output when the pipe moves
    a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s_valid_reg) |=> out_valid_reg)
        else $error("beat lost between integral stage and output");
`endif

endmodule

// ===== src/angle_position_pid_loop.sv =====
// angle_position_pid_loop: encoder count in, clamped Q16.16 current reference out.
// An accepted input beat passes the queue and the product, integral and output
// registers to out_valid. Throughput: one beat per cycle while out_stall is low;
// products, integral add and output sum are each one register stage, and the
// integral loop is a single 48-bit add and clamp. Reset: rst_n clears the settings,
// stage valids, the integral, the last error and the queue pointers; data registers
// are left as they are. Depends on apid_pkg, apid_front, apid_queue and apid_back.
module angle_position_pid_loop (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_write,
    input  logic [apid_pkg::CfgIdxW-1:0]        cfg_addr,
    input  logic [apid_pkg::DataW-1:0]          cfg_data,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [apid_pkg::EncW-1:0]           encoder_count,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [apid_pkg::DataW-1:0]   current_ref,
    output logic signed [apid_pkg::ErrW-1:0]    pos_error,
    output logic                                out_clamped
);

    apid_pkg::front_cfg_t    front_cfg_reg;
    apid_pkg::front_cfg_t    front_cfg_next;
    apid_pkg::back_cfg_t     back_cfg_reg;
    apid_pkg::back_cfg_t     back_cfg_next;
    apid_pkg::item_t         front_item;
    apid_pkg::item_t         queue_item;
    apid_pkg::queue_status_t q_status;
    logic                    in_accept;
    logic                    q_pop;

    // Configuration register decode
    always_comb
    begin
        front_cfg_next = front_cfg_reg;
        back_cfg_next  = back_cfg_reg;
        if (cfg_write)
        begin
            case (apid_pkg::cfg_index_t'(cfg_addr))
                apid_pkg::CFG_GAIN_P:      back_cfg_next.gain_p      = cfg_data;
                apid_pkg::CFG_GAIN_I:      back_cfg_next.gain_i      = cfg_data;
                apid_pkg::CFG_GAIN_D:      back_cfg_next.gain_d      = cfg_data;
                apid_pkg::CFG_TARGET:
                    front_cfg_next.target_count = cfg_data[apid_pkg::EncW-1:0];
                apid_pkg::CFG_ZERO:
                    front_cfg_next.zero_count   = cfg_data[apid_pkg::EncW-1:0];
                apid_pkg::CFG_LIMIT_LOW:   back_cfg_next.limit_low   = cfg_data;
                apid_pkg::CFG_LIMIT_HIGH:  back_cfg_next.limit_high  = cfg_data;
                apid_pkg::CFG_DIR_REVERSE: front_cfg_next.dir_reverse = cfg_data[0];
                default:
                begin
                    front_cfg_next = front_cfg_reg;
                    back_cfg_next  = back_cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cfg_reg <= '0;
            back_cfg_reg  <= '0;
        end
        else
        begin
            front_cfg_reg <= front_cfg_next;
            back_cfg_reg  <= back_cfg_next;
        end
    end

    // Input handshake: stall only on a full queue
    assign in_stall  = q_status.full;
    assign in_accept = in_valid && !in_stall;

    apid_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (front_cfg_reg),
        .accept        (in_accept),
        .encoder_count (encoder_count),
        .item          (front_item)
    );

    apid_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_accept),
        .item_in  (front_item),
        .pop      (q_pop),
        .item_out (queue_item),
        .status   (q_status)
    );

    apid_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (back_cfg_reg),
        .item        (queue_item),
        .item_valid  (q_status.not_empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .current_ref (current_ref),
        .pos_error   (pos_error),
        .out_clamped (out_clamped)
    );

endmodule

// ===== dv/tb_angle_position_pid_loop.sv =====
// Testbench for angle_position_pid_loop: drives encoder beats under random idling
// and back-pressure, predicts each PID result in place and checks every field.
// Depends on apid_pkg and the angle_position_pid_loop RTL.
`timescale 1ns / 1ps

module tb_angle_position_pid_loop;

    localparam int DataW        = apid_pkg::DataW;
    localparam int ErrW         = apid_pkg::ErrW;
    localparam int EncW         = apid_pkg::EncW;
    localparam int CountsPerRev = apid_pkg::CountsPerRev;
    localparam int HalfRev      = apid_pkg::HalfRev;

    localparam int PipeLatency = 3;
    localparam int QuietLimit  = 4000;
    localparam int HoldCycles  = 400;

    typedef struct {
        logic signed [DataW-1:0] current_ref;
        logic signed [ErrW-1:0]  pos_error;
        logic                    clamped;
    } pid_result_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    apid_pkg::cfg_index_t cfg_addr = apid_pkg::CFG_GAIN_P;
    logic [DataW-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [EncW-1:0]     encoder_count = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [DataW-1:0] current_ref;
    logic signed [ErrW-1:0]  pos_error;
    logic                out_clamped;

    // Controller copy of the register file and loop state
    longint          gain_p_q, gain_i_q, gain_d_q, lim_lo_q, lim_hi_q;
    logic [EncW-1:0] target_q, zero_q;
    bit              reverse_q;
    longint          integral_acc, last_error;

    pid_result_t expected_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int quiet_cycles;
    int error_count;
    int beats_sent;
    int results_checked;
    int clamp_count;
    int settings_used;

    angle_position_pid_loop i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .encoder_count (encoder_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .current_ref   (current_ref),
        .pos_error     (pos_error),
        .out_clamped   (out_clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Controller prediction
    // ---------------------------------------------------------------
    function automatic longint mod_rev(input longint v);
        longint r;
        r = v % CountsPerRev;
        if (r < 0)
            r += CountsPerRev;
        return r;
    endfunction

    // High limit tested first; inverted limits give limit_high above it, else limit_low
    function automatic longint clamp_to_limits(input longint v, output bit hit);
        hit = 1'b1;
        if (v > lim_hi_q)
            return lim_hi_q;
        if (v < lim_lo_q)
            return lim_lo_q;
        hit = 1'b0;
        return v;
    endfunction

    function automatic void predict_pid_step(input logic [EncW-1:0] count);
        longint      angle, rel, err, acc, drive;
        bit          hit;
        pid_result_t res;
        angle = reverse_q ? -longint'(count) : longint'(count);
        rel   = mod_rev(angle - mod_rev(longint'(zero_q)));
        err   = mod_rev(longint'(target_q)) - rel;
        // exact half turn is left alone
        if (err > HalfRev)
            err -= CountsPerRev;
        else if (err < -HalfRev)
            err += CountsPerRev;
        acc          = integral_acc + gain_i_q * err;
        integral_acc = clamp_to_limits(acc, hit);
        drive        = gain_p_q * err + integral_acc + gain_d_q * (err - last_error);
        drive        = clamp_to_limits(drive, hit);
        last_error   = err;
        res.current_ref = drive[DataW-1:0];
        res.pos_error   = err[ErrW-1:0];
        res.clamped     = hit;
        expected_results.push_back(res);
    endfunction

    // Encoder count that puts the error offset counts below the half-turn boundary
    function automatic logic [EncW-1:0] half_turn_count(input int offset);
        longint rel;
        rel = mod_rev(longint'(target_q) - HalfRev + offset);
        if (reverse_q)
            return EncW'(mod_rev(-(rel + longint'(zero_q))));
        return EncW'(mod_rev(rel + longint'(zero_q)));
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_count(input logic [EncW-1:0] count);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid      <= 1'b0;
            encoder_count <= EncW'($urandom);
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        encoder_count <= count;
        do
            @(posedge clk);
        while (in_stall);
        predict_pid_step(count);
        beats_sent++;
    endtask

    // Stop offering and wait for every pending result plus pipeline slack
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (PipeLatency + 2) @(posedge clk);
    endtask

    task automatic write_reg(input apid_pkg::cfg_index_t idx,
                             input logic [DataW-1:0] val);
        cfg_write <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            apid_pkg::CFG_GAIN_P:      gain_p_q  = longint'($signed(val));
            apid_pkg::CFG_GAIN_I:      gain_i_q  = longint'($signed(val));
            apid_pkg::CFG_GAIN_D:      gain_d_q  = longint'($signed(val));
            apid_pkg::CFG_TARGET:      target_q  = val[EncW-1:0];
            apid_pkg::CFG_ZERO:        zero_q    = val[EncW-1:0];
            apid_pkg::CFG_LIMIT_LOW:   lim_lo_q  = longint'($signed(val));
            apid_pkg::CFG_LIMIT_HIGH:  lim_hi_q  = longint'($signed(val));
            apid_pkg::CFG_DIR_REVERSE: reverse_q = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [DataW-1:0] kp, ki, kd,
                                  input logic [EncW-1:0] tgt, zro,
                                  input logic [DataW-1:0] lo, hi,
                                  input bit rev);
        drain();
        write_reg(apid_pkg::CFG_GAIN_P, kp);
        write_reg(apid_pkg::CFG_GAIN_I, ki);
        write_reg(apid_pkg::CFG_GAIN_D, kd);
        write_reg(apid_pkg::CFG_TARGET, DataW'(tgt));
        write_reg(apid_pkg::CFG_ZERO, DataW'(zro));
        write_reg(apid_pkg::CFG_LIMIT_LOW, lo);
        write_reg(apid_pkg::CFG_LIMIT_HIGH, hi);
        write_reg(apid_pkg::CFG_DIR_REVERSE, DataW'(rev));
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // Output side: stall generation and result checking
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_checker
        pid_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got ref %0d err %0d",
                         $time, current_ref, pos_error);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (current_ref !== want.current_ref)
                begin
                    $display("%0t: current_ref expected %0d got %0d",
                             $time, want.current_ref, current_ref);
                    error_count++;
                end
                if (pos_error !== want.pos_error)
                begin
                    $display("%0t: pos_error expected %0d got %0d",
                             $time, want.pos_error, pos_error);
                    error_count++;
                end
                if (out_clamped !== want.clamped)
                begin
                    $display("%0t: out_clamped expected %0b got %0b",
                             $time, want.clamped, out_clamped);
                    error_count++;
                end
                results_checked++;
                if (out_clamped === 1'b1)
                    clamp_count++;
            end
        end
        // long hold-off overrides the random stall
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: too long without any beat moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("tb_angle_position_pid_loop failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Random settings
    // ---------------------------------------------------------------
    function automatic logic [DataW-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return $urandom;
            4, 5:    return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
            default: return $urandom_range(0, 32'h1FFF) - 32'h1000;
        endcase
    endfunction

    task automatic randomize_settings();
        logic [DataW-1:0] lo, hi;
        case ($urandom_range(0, 9))
            0:
            begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            1:
            begin
                // inverted limits
                lo = $urandom_range(0, 32'h0FFF_FFFF);
                hi = -$urandom_range(1, 32'h0FFF_FFFF);
            end
            2:
            begin
                lo = $urandom;
                hi = lo;
            end
            default:
            begin
                lo = $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
                hi = lo + $urandom_range(0, 32'h0FFF_FFFF);
            end
        endcase
        apply_settings(rand_gain(), rand_gain(), rand_gain(),
                       EncW'($urandom), EncW'($urandom), lo, hi,
                       1'($urandom_range(0, 1)));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Registers at their reset values: current_ref stays at zero
    task automatic test_reset_values();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_count('0);
        send_count(EncW'(CountsPerRev - 1));
    endtask

    // Field extremes, wrap edges, half turn, saturation and inverted limits
    task automatic test_directed_corners();
        logic [EncW-1:0] s1_counts[8] = '{14'd0, 14'd8192, 14'd16383, 14'd1,
                                          14'd8191, 14'd8193, 14'd4096, 14'd12288};
        logic [EncW-1:0] s2_counts[8] = '{14'd0, 14'd16383, 14'd8192, 14'd1,
                                          14'd100, 14'd8191, 14'd8193, 14'd16000};
        logic [EncW-1:0] s3_counts[6] = '{14'd0, 14'd16383, 14'd1, 14'd8192,
                                          14'd8193, 14'd2};
        apply_settings(32'h0001_0000, 32'h0000_0100, -32'h8000, '0, '0,
                       32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        foreach (s1_counts[k])
            send_count(s1_counts[k]);
        apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 14'h3FFF, 14'h3FFF,
                       -32'h10_0000, 32'h10_0000, 1'b1);
        foreach (s2_counts[k])
            send_count(s2_counts[k]);
        apply_settings(-32'h3000, 32'h7FFF, 32'h1, 14'd8192, 14'd1,
                       32'h5_0000, -32'h5_0000, 1'b0);
        foreach (s3_counts[k])
            send_count(s3_counts[k]);
    endtask

    // Trajectories that settle, jitter and cross the half-turn edge
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int beats);
        int              k;
        logic [EncW-1:0] pos;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        pos = EncW'($urandom);
        for (k = 0; k < beats; k++)
        begin
            if (k % 65 == 0)
                randomize_settings();
            case ($urandom_range(0, 19))
                0:       pos = half_turn_count(int'($urandom_range(0, 2)) - 1);
                1, 2:    pos = EncW'($urandom);
                3:       pos = pos + EncW'(HalfRev);
                default: pos = pos + EncW'($urandom_range(0, 64)) - EncW'(32);
            endcase
            send_count(pos);
        end
    endtask

    // Long receiver hold-off while beats keep coming, then a full pause
    task automatic test_backpressure();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        randomize_settings();
        hold_left = HoldCycles;
        for (k = 0; k < 30; k++)
            send_count(EncW'($urandom));
        drain();
        for (k = 0; k < 10; k++)
            send_count(EncW'($urandom));
        drain();
        recv_idle_pct = 50;
        for (k = 0; k < 10; k++)
            send_count(EncW'($urandom));
    endtask

    initial
    begin
        gain_p_q     = 0;
        gain_i_q     = 0;
        gain_d_q     = 0;
        lim_lo_q     = 0;
        lim_hi_q     = 0;
        target_q     = '0;
        zero_q       = '0;
        reverse_q    = 1'b0;
        integral_acc = 0;
        last_error   = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        error_count  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_corners();
        test_random_traffic(35, 88, 260);
        test_random_traffic(88, 35, 260);
        test_random_traffic(0, 0, 260);
        test_backpressure();
        drain();

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_results.size());
            error_count++;
        end
        $display("Run covered %0d encoder beats over %0d register settings.",
                 beats_sent, settings_used);
        $display("%0d results checked, %0d of them clamped, %0d mismatches.",
                 results_checked, clamp_count, error_count);
        if (error_count == 0)
            $display("tb_angle_position_pid_loop passed");
        else
            $display("tb_angle_position_pid_loop failed");
        $finish;
    end

endmodule
